>>> rtl/core/hcb_pkg.sv
`default_nettype none

package hcb_pkg;

	// Field widths of the words on the ports and of the internal node weight
	localparam int SYM_W  = 7;
	localparam int WGT_W  = 24;
	localparam int NWT_W  = 31;
	localparam int CODE_W = 63;
	localparam int LEN_W  = 6;

	// Sequencer states
	typedef enum logic [3:0] {
		ST_IDLE,
		ST_BINIT,
		ST_BCHK,
		ST_SINIT,
		ST_SCAN,
		ST_DRAIN,
		ST_MRGA,
		ST_MRGB,
		ST_WINIT,
		ST_WREAD,
		ST_WSTEP,
		ST_EMIT
	} state_t;

	// Commands from the sequencer to the datapath
	typedef struct packed {
		logic load;
		logic build_init;
		logic scan_init;
		logic scan_step;
		logic merge_a;
		logic merge_b;
		logic walk_init;
		logic walk_read;
		logic walk_step;
		logic emit;
	} cmd_t;

	// Status from the datapath to the sequencer
	typedef struct packed {
		logic scan_end;
		logic build_done;
		logic cur_has_par;
		logic leaf_last;
	} sts_t;

endpackage

`default_nettype wire

>>> rtl/core/hcb_ctrl.sv
`default_nettype none

module hcb_ctrl (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         start,
	input  wire logic         last_symbol,
	input  wire hcb_pkg::sts_t sts,
	output hcb_pkg::cmd_t     cmd,
	output logic              busy,
	output logic              out_valid
);
	import hcb_pkg::*;

	state_t state_q;
	state_t state_d;
	logic   accept;

	assign accept = start && (state_q == ST_IDLE);

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept && last_symbol) state_d = ST_BINIT;
			end
			ST_BINIT: state_d = ST_BCHK;
			ST_BCHK: begin
				state_d = sts.build_done ? ST_WINIT : ST_SINIT;
			end
			ST_SINIT: state_d = ST_SCAN;
			ST_SCAN: begin
				if (sts.scan_end) state_d = ST_DRAIN;
			end
			ST_DRAIN: state_d = ST_MRGA;
			ST_MRGA:  state_d = ST_MRGB;
			ST_MRGB:  state_d = ST_BCHK;
			ST_WINIT: state_d = ST_WREAD;
			ST_WREAD: begin
				state_d = sts.cur_has_par ? ST_WSTEP : ST_EMIT;
			end
			ST_WSTEP: state_d = ST_WREAD;
			ST_EMIT: begin
				state_d = sts.leaf_last ? ST_IDLE : ST_WINIT;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Outputs
	always_comb begin
		cmd        = '0;
		busy       = (state_q != ST_IDLE);
		out_valid  = 1'b0;
		cmd.load   = accept;
		case (state_q)
			ST_BINIT: cmd.build_init = 1'b1;
			ST_SINIT: cmd.scan_init  = 1'b1;
			ST_SCAN:  cmd.scan_step  = !sts.scan_end;
			ST_MRGA:  cmd.merge_a    = 1'b1;
			ST_MRGB:  cmd.merge_b    = 1'b1;
			ST_WINIT: cmd.walk_init  = 1'b1;
			ST_WREAD: cmd.walk_read  = sts.cur_has_par;
			ST_WSTEP: cmd.walk_step  = 1'b1;
			ST_EMIT: begin
				cmd.emit  = 1'b1;
				out_valid = 1'b1;
			end
			default: begin
			end
		endcase
	end

endmodule

`default_nettype wire

>>> rtl/core/hcb_dp.sv
`default_nettype none

module hcb_dp #(
	parameter int MAX_SYMBOLS = 64
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire hcb_pkg::cmd_t                   cmd,
	output hcb_pkg::sts_t                        sts,
	input  wire logic [hcb_pkg::SYM_W-1:0]       symbol,
	input  wire logic [hcb_pkg::WGT_W-1:0]       weight,
	output logic      [hcb_pkg::SYM_W-1:0]       out_symbol,
	output logic      [hcb_pkg::CODE_W-1:0]      code_bits,
	output logic      [hcb_pkg::LEN_W-1:0]       code_length,
	output logic                                 last_code
);
	import hcb_pkg::*;

	localparam int NODES = 2 * MAX_SYMBOLS - 1;
	localparam int NW    = $clog2(NODES);
	localparam int LW    = $clog2(MAX_SYMBOLS);
	localparam int CW    = $clog2(MAX_SYMBOLS + 1);

	// Node and leaf stores
	logic [NWT_W-1:0] wmem [NODES];
	logic [NW-1:0]    pmem [NODES];
	logic [SYM_W-1:0] smem [MAX_SYMBOLS];

	// Per-node flags: has a parent, is the right child
	logic [NODES-1:0] has_par_q;
	logic [NODES-1:0] side_q;

	logic [CW-1:0]    cnt_q;
	logic [NW-1:0]    node_q;
	logic [NW-1:0]    scan_q;

	logic             vld_s1;
	logic [NW-1:0]    idx_s1;
	logic [NWT_W-1:0] w_s1;

	logic             found1_q, found2_q;
	logic [NW-1:0]    b1_idx_q, b2_idx_q;
	logic [NWT_W-1:0] b1_w_q, b2_w_q;

	logic [CW-1:0]    leaf_q;
	logic [NW-1:0]    cur_q;
	logic [NW-1:0]    par_rd_q;
	logic [SYM_W-1:0] sym_rd_q;
	logic [CODE_W-1:0] code_q;
	logic [LEN_W-1:0] len_q;

	logic             can_load;
	logic [NW:0]      last_node;
	logic [NW-1:0]    wr_idx;
	logic [NWT_W-1:0] wr_data;
	logic             wr_en;

	assign can_load  = cnt_q < CW'(MAX_SYMBOLS);
	assign last_node = ((NW + 1)'(cnt_q) << 1) - (NW + 1)'(1);

	assign sts.scan_end    = (scan_q == node_q);
	assign sts.build_done  = ({1'b0, node_q} == last_node);
	assign sts.cur_has_par = has_par_q[cur_q];
	assign sts.leaf_last   = (CW'(leaf_q + CW'(1)) == cnt_q);

	assign out_symbol  = sym_rd_q;
	assign code_bits   = code_q;
	assign code_length = len_q;
	assign last_code   = sts.leaf_last;

	// Select the weight write: a loaded leaf or a merged node
	always_comb begin
		wr_en   = 1'b0;
		wr_idx  = node_q;
		wr_data = b1_w_q + b2_w_q;
		if (cmd.load && can_load) begin
			wr_en   = 1'b1;
			wr_idx  = NW'(cnt_q);
			wr_data = NWT_W'(weight);
		end else if (cmd.merge_a) begin
			wr_en = 1'b1;
		end
	end

	// Weight store
	always_ff @(posedge clk) begin
		if (wr_en) wmem[wr_idx] <= wr_data;
		w_s1 <= wmem[scan_q];
	end

	// Parent store
	always_ff @(posedge clk) begin
		if (cmd.merge_a) begin
			pmem[b1_idx_q] <= node_q;
		end else if (cmd.merge_b) begin
			pmem[b2_idx_q] <= node_q;
		end
		if (cmd.walk_read) par_rd_q <= pmem[cur_q];
	end

	// Leaf symbol store
	always_ff @(posedge clk) begin
		if (cmd.load && can_load) smem[cnt_q[LW-1:0]] <= symbol;
		if (cmd.walk_init) sym_rd_q <= smem[leaf_q[LW-1:0]];
	end

	// Control counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= cmd.scan_step && !has_par_q[scan_q];
			if (cmd.load && can_load) begin
				cnt_q <= CW'(cnt_q + CW'(1));
			end else if (cmd.emit && sts.leaf_last) begin
				cnt_q <= '0;
			end
		end
	end

	// Build datapath: scan, two-minimum track, merge; then the code walk
	always_ff @(posedge clk) begin
		idx_s1 <= scan_q;
		if (cmd.load && can_load) has_par_q[wr_idx] <= 1'b0;
		if (cmd.build_init) begin
			node_q <= NW'(cnt_q);
			leaf_q <= '0;
		end
		if (cmd.scan_init) begin
			scan_q   <= '0;
			found1_q <= 1'b0;
			found2_q <= 1'b0;
		end
		if (cmd.scan_step) scan_q <= NW'(scan_q + NW'(1));
		if (vld_s1) begin
			if (!found1_q || (w_s1 < b1_w_q)) begin
				b2_idx_q <= b1_idx_q;
				b2_w_q   <= b1_w_q;
				found2_q <= found1_q;
				b1_idx_q <= idx_s1;
				b1_w_q   <= w_s1;
				found1_q <= 1'b1;
			end else if (!found2_q || (w_s1 < b2_w_q)) begin
				b2_idx_q <= idx_s1;
				b2_w_q   <= w_s1;
				found2_q <= 1'b1;
			end
		end
		if (cmd.merge_a) begin
			has_par_q[node_q]   <= 1'b0;
			has_par_q[b1_idx_q] <= 1'b1;
			side_q[b1_idx_q]    <= 1'b0;
		end
		if (cmd.merge_b) begin
			has_par_q[b2_idx_q] <= 1'b1;
			side_q[b2_idx_q]    <= 1'b1;
			node_q              <= NW'(node_q + NW'(1));
		end
		// Walk from a leaf to the root, one edge per parent memory read and step
		if (cmd.walk_init) begin
			cur_q  <= NW'(leaf_q[LW-1:0]);
			code_q <= '0;
			len_q  <= '0;
		end
		if (cmd.walk_step) begin
			code_q[len_q] <= side_q[cur_q];
			len_q         <= LEN_W'(len_q + LEN_W'(1));
			cur_q         <= par_rd_q;
		end
		if (cmd.emit) leaf_q <= CW'(leaf_q + CW'(1));
	end

endmodule

`default_nettype wire

>>> rtl/core/huffman_tree_code_builder_core.sv
`default_nettype none

// Huffman code builder. Load one symbol and weight per start while busy is low;
// the word with last_symbol set starts the build, and busy stays high until the
// codes are out. Up to MAX_SYMBOLS symbols are kept, later ones are dropped.
// Each of the n-1 merges scans all nodes made so far through the single
// read port of the weight memory, one node per cycle. Then one code word per
// symbol is given in load order with out_valid high for one cycle, found with
// one parent memory read per tree level. The receiver cannot stall: take each
// word in the cycle it is shown.
module huffman_tree_code_builder_core #(
	parameter int MAX_SYMBOLS = 64
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        start,
	output logic                             busy,
	input  wire logic [hcb_pkg::SYM_W-1:0]   symbol,
	input  wire logic [hcb_pkg::WGT_W-1:0]   weight,
	input  wire logic                        last_symbol,
	output logic                             out_valid,
	output logic      [hcb_pkg::SYM_W-1:0]   out_symbol,
	output logic      [hcb_pkg::CODE_W-1:0]  code_bits,
	output logic      [hcb_pkg::LEN_W-1:0]   code_length,
	output logic                             last_code
);
	import hcb_pkg::*;

	cmd_t cmd;
	sts_t sts;

	hcb_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.last_symbol(last_symbol),
		.sts        (sts),
		.cmd        (cmd),
		.busy       (busy),
		.out_valid  (out_valid)
	);

	hcb_dp #(
		.MAX_SYMBOLS(MAX_SYMBOLS)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.sts        (sts),
		.symbol     (symbol),
		.weight     (weight),
		.out_symbol (out_symbol),
		.code_bits  (code_bits),
		.code_length(code_length),
		.last_code  (last_code)
	);

`ifndef SYNTHESIS
	// A result word only appears while busy
	a_out_busy: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> busy) else $error("result word while idle");

	// Result words are never back to back
	a_out_gap: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |=> !out_valid) else $error("result words back to back");

	// A last word starts a build
	a_last_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && last_symbol) |=> busy) else $error("build did not start");

	// A plain load leaves the block idle
	a_load_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && !last_symbol) |=> !busy) else $error("load left block busy");
`endif

endmodule

`default_nettype wire
